// File: sv/atrr_pkg.sv
// Shared types and constants for the AT response receiver.
`default_nettype none
package atrr_pkg;
  localparam int LINE_HOLD = 63;
  localparam int LINE_AW = 6;
  localparam int RESP_DEPTH = 1024;
  localparam int RESP_AW = 10;
  localparam int CNT_W = 11;
  localparam int HIST_DEPTH = 16;
  localparam int PROMPT_MAX = 8;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] MODE_LINE = 2'd0;
  localparam logic [1:0] MODE_PROMPT = 2'd1;
  localparam logic [1:0] MODE_BINARY = 2'd2;

  localparam logic [1:0] KIND_URC = 2'd0;
  localparam logic [1:0] KIND_OK = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [1:0] REG_PROMPT_BYTES = 2'd0;
  localparam logic [1:0] REG_PROMPT_LENGTH = 2'd1;
  localparam logic [1:0] REG_NEED_LENGTH = 2'd2;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_R = 8'h52;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_run;
    logic [10:0] held_count;
    logic       overflow_seen;
  } result_t;
endpackage
`default_nettype wire

// File: sv/atrr_line_ram.sv
// Line buffer memory: one write port, one registered read port.
`default_nettype none
module atrr_line_ram (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [5:0] waddr,
  input  wire logic [7:0] wdata,
  input  wire logic [5:0] raddr,
  output logic [7:0]      rdata
);
  logic [7:0] mem [0:atrr_pkg::LINE_HOLD-1];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/atrr_resp_ram.sv
// Response memory: one write port, one registered read port.
`default_nettype none
module atrr_resp_ram (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [9:0] waddr,
  input  wire logic [7:0] wdata,
  input  wire logic [9:0] raddr,
  output logic [7:0]      rdata
);
  logic [7:0] mem [0:atrr_pkg::RESP_DEPTH-1];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/at_response_receiver_unit.sv
// Top level of the AT response receiver.
// Usage: s_axis carries one command item per transfer: tuser = command,
// tdata = {read_index, task_mode, rx_byte} from the highest bit down. m_axis
// returns result items: tdata = {held_count, data_byte}, tuser =
// {overflow_seen, kind}, tlast = last_of_run. The cfg channel writes
// prompt_bytes (0), prompt_length (1) and need_length (2) while idle.
// Throughput: one item at a time, since the input is ready only when idle.
// The newline that closes a line of more than two bytes starts a walk of the
// line memory, a byte per cycle (one read and one write port each): a URC
// run is sent out byte by byte, each byte only while the output is free, and
// any other line is copied into the response memory; a line that does not
// fit is dropped without a walk. A read result is registered in the output
// stage from the read state and a task end from a prompt or binary byte from
// the end state; a line status follows the walk, also from the end state.
// Reset clears all control state; memories keep their contents and are
// tracked by counts. A stalled receiver holds the output register and stops
// a URC walk, a read or the task end until the item is taken.
`default_nettype none
module at_response_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // rx_byte[7:0], task_mode[9:8], read_index[19:10], pad
  input  wire logic [23:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // data_byte[7:0], held_count[18:8], pad
  output logic [23:0]      m_axis_tdata,
  // kind[1:0], overflow_seen[2]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_READ = 6'b000100,
    ST_WALK = 6'b001000,
    ST_END  = 6'b010000,
    ST_HEAD = 6'b100000
  } state_t;

  state_t state;
  logic [63:0] prompt_bytes;
  logic [3:0]  prompt_length;
  logic [10:0] need_length;
  logic [5:0]  line_count;
  logic        line_discarding;
  logic [10:0] response_count;
  logic        task_active;
  logic [1:0]  mode_now;
  logic [63:0] prompt_history;
  logic [4:0]  history_fill;
  logic        dropped_flag;

  logic [1:0]  cmd;
  logic [7:0]  rxb;
  logic [1:0]  tmode;
  logic [9:0]  ridx;
  logic [7:0]  hdr [0:4];
  logic [5:0]  walk;
  logic        walk_urc;
  logic        walk_store;
  logic [5:0]  walk_n;

  atrr_pkg::result_t out_reg;
  logic        out_valid;

  logic        lwe;
  logic [5:0]  lwaddr, lraddr;
  logic [7:0]  lwdata, lrdata;
  logic        rwe;
  logic [9:0]  rwaddr, rraddr;
  logic [7:0]  rwdata, rrdata;
  logic        rd_ok;

  atrr_line_ram u_line (.clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
    .raddr(lraddr), .rdata(lrdata));
  atrr_resp_ram u_resp (.clk(clk), .we(rwe), .waddr(rwaddr), .wdata(rwdata),
    .raddr(rraddr), .rdata(rrdata));

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, out_reg.held_count, out_reg.data_byte};
  assign m_axis_tuser = {out_reg.overflow_seen, out_reg.kind};
  assign m_axis_tlast = out_reg.last_of_run;

  logic out_free;
  assign out_free = !out_valid || m_axis_tready;

  // Prompt compare on the current history
  logic [63:0] pmask;
  logic        pmatch;
  always_comb begin
    pmask = '1;
    if (prompt_length < 4'd8) begin
      pmask = (64'd1 << {prompt_length, 3'd0}) - 64'd1;
    end
    pmatch = (prompt_length != 4'd0) && (prompt_length <= 4'(atrr_pkg::PROMPT_MAX)) &&
             ({1'b0, prompt_length} <= history_fill) &&
             ((prompt_history & pmask) == (prompt_bytes & pmask));
  end

  // Memory port steering
  always_comb begin
    lwe = 1'b0;
    lwaddr = line_count;
    lwdata = rxb;
    lraddr = walk;
    rwe = 1'b0;
    rwaddr = response_count[9:0];
    rwdata = rxb;
    rraddr = ridx;
    if (state == ST_EXEC && cmd == atrr_pkg::CMD_BYTE) begin
      if (!task_active || mode_now == atrr_pkg::MODE_LINE) begin
        lwe = !line_discarding && (line_count < 6'(atrr_pkg::LINE_HOLD));
      end else if (mode_now == atrr_pkg::MODE_BINARY) begin
        rwe = (response_count < 11'(atrr_pkg::RESP_DEPTH));
      end
    end
    // Re-read the waiting URC byte while the output is stalled
    if (state == ST_WALK && walk_urc && walk != 6'd0 && !out_free) begin
      lraddr = walk - 6'd1;
    end
    if (state == ST_WALK && walk_store && walk != 6'd0) begin
      rwe = 1'b1;
      rwaddr = response_count[9:0] + 10'(walk - 6'd1);
      rwdata = lrdata;
    end
  end

  function automatic atrr_pkg::result_t mk(input logic [1:0] k, input logic [7:0] b,
                                             input logic l, input logic [10:0] c,
                                             input logic d);
    atrr_pkg::result_t r;
    r.kind = k; r.data_byte = b; r.last_of_run = l;
    r.held_count = c; r.overflow_seen = d;
    return r;
  endfunction

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      prompt_bytes <= '0; prompt_length <= '0; need_length <= '0;
      line_count <= '0; line_discarding <= 1'b0; response_count <= '0;
      task_active <= 1'b0; mode_now <= atrr_pkg::MODE_LINE;
      prompt_history <= '0; history_fill <= '0; dropped_flag <= 1'b0;
      out_valid <= 1'b0; walk <= '0; walk_urc <= 1'b0; walk_store <= 1'b0;
      walk_n <= '0;
    end else begin
      logic put;
      put = 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            priority case (cfg_index)
              atrr_pkg::REG_PROMPT_BYTES: prompt_bytes <= cfg_data;
              atrr_pkg::REG_PROMPT_LENGTH: prompt_length <= cfg_data[3:0];
              atrr_pkg::REG_NEED_LENGTH: need_length <= cfg_data[10:0];
              default: ;
            endcase
          end
          if (s_axis_tvalid) begin
            cmd <= s_axis_tuser;
            rxb <= s_axis_tdata[7:0];
            tmode <= s_axis_tdata[9:8];
            ridx <= s_axis_tdata[19:10];
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd == atrr_pkg::CMD_START) begin
            if (tmode <= atrr_pkg::MODE_BINARY) begin
              task_active <= 1'b1; mode_now <= tmode;
            end
            state <= ST_IDLE;
          end else if (cmd == atrr_pkg::CMD_READ) begin
            rd_ok <= ({1'b0, ridx} < response_count);
            state <= ST_READ;
          end else if (cmd == atrr_pkg::CMD_BYTE) begin
            if (!task_active || mode_now == atrr_pkg::MODE_LINE) begin
              if (line_discarding) begin
                if (rxb == atrr_pkg::CH_NL) begin
                  line_discarding <= 1'b0; line_count <= '0;
                end
                state <= ST_IDLE;
              end else if (line_count >= 6'(atrr_pkg::LINE_HOLD)) begin
                if (rxb == atrr_pkg::CH_NL) line_count <= '0;
                else line_discarding <= 1'b1;
                state <= ST_IDLE;
              end else begin
                if (line_count < 6'd5) hdr[line_count[2:0]] <= rxb;
                if (rxb == atrr_pkg::CH_NL) begin
                  walk_n <= line_count + 6'd1;
                  line_count <= '0;
                  if (line_count + 6'd1 > 6'd2) state <= ST_HEAD;
                  else state <= ST_IDLE;
                end else begin
                  line_count <= line_count + 6'd1;
                  state <= ST_IDLE;
                end
              end
            end else if (mode_now == atrr_pkg::MODE_PROMPT) begin
              if (history_fill < 5'(atrr_pkg::HIST_DEPTH)) begin
                prompt_history <= {prompt_history[55:0], rxb};
                history_fill <= history_fill + 5'd1;
              end
              state <= ST_END;
            end else begin
              if (response_count >= 11'(atrr_pkg::RESP_DEPTH)) begin
                dropped_flag <= 1'b1;
                state <= ST_IDLE;
              end else begin
                response_count <= response_count + 11'd1;
                state <= ST_END;
              end
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_reg <= mk(atrr_pkg::KIND_READ, rd_ok ? rrdata : 8'd0, 1'b0,
                          response_count, dropped_flag);
            put = 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_HEAD: begin
          walk <= '0;
          walk_urc <= (hdr[0] == atrr_pkg::CH_PLUS);
          walk_store <= (hdr[0] != atrr_pkg::CH_PLUS) &&
                        ({5'd0, walk_n} + response_count <= 11'(atrr_pkg::RESP_DEPTH));
          state <= ST_WALK;
        end
        ST_WALK: begin
          // walk index w: read address w, data of w-1 arrives now
          if (walk_urc) begin
            if (walk == 6'd0) begin
              walk <= 6'd1;
            end else if (out_free) begin
              out_reg <= mk(atrr_pkg::KIND_URC, lrdata, walk == walk_n,
                            response_count, dropped_flag);
              put = 1'b1;
              if (walk == walk_n) state <= ST_IDLE;
              else walk <= walk + 6'd1;
            end
          end else if (walk_store && walk != walk_n) begin
            walk <= walk + 6'd1;
          end else begin
            if (walk_store) response_count <= response_count + {5'd0, walk_n};
            else dropped_flag <= 1'b1;
            state <= ST_END;
          end
        end
        ST_END: begin
          // Resolve task end for line, prompt and binary paths
          logic fin;
          logic [1:0] k;
          fin = 1'b0;
          k = atrr_pkg::KIND_OK;
          if (!task_active || mode_now == atrr_pkg::MODE_LINE) begin
            if (hdr[0] == atrr_pkg::CH_O && hdr[1] == atrr_pkg::CH_K) fin = 1'b1;
            else if (walk_n >= 6'd5 && hdr[0] == atrr_pkg::CH_E &&
                     hdr[1] == atrr_pkg::CH_R && hdr[2] == atrr_pkg::CH_R &&
                     hdr[3] == atrr_pkg::CH_O && hdr[4] == atrr_pkg::CH_R) begin
              fin = 1'b1; k = atrr_pkg::KIND_ERR;
            end
          end else if (mode_now == atrr_pkg::MODE_PROMPT) begin
            if (pmatch) begin
              if (need_length != 11'd0) begin
                prompt_history <= '0; history_fill <= '0;
                response_count <= '0; dropped_flag <= 1'b0;
                mode_now <= atrr_pkg::MODE_BINARY;
              end else fin = 1'b1;
            end
          end else begin
            fin = (response_count >= need_length);
          end
          if (!fin) begin
            state <= ST_IDLE;
          end else if (!task_active || out_free) begin
            if (task_active) begin
              out_reg <= mk(k, 8'd0, 1'b0, response_count, dropped_flag);
              put = 1'b1;
            end
            task_active <= 1'b0; mode_now <= atrr_pkg::MODE_LINE;
            response_count <= '0; dropped_flag <= 1'b0;
            prompt_history <= '0; history_fill <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // Load a new item or drop the taken one
      if (put) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: sv/atrr_checker.sv
// Port-level checker for the AT response receiver, bound to the top level.
`default_nettype none
module atrr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast,
  input wire logic        cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_last_urc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == atrr_pkg::KIND_URC)
    else $error("tlast on non-URC item");
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("two items taken back to back");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == s_axis_tready)
    else $error("config and input ready disagree");
endmodule

bind at_response_receiver_unit atrr_checker u_chk (.clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast), .cfg_ready(cfg_ready));
`default_nettype wire

// File: dv/tb_at_response_receiver_unit.sv
// Testbench for the AT response receiver: directed table and sequences, then random traffic.
`default_nettype none
module tb_at_response_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import atrr_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] rx;
    logic [1:0] mode;
    logic [9:0] idx;
  } cmd_item_t;

  // directed row: item, plus an optional typed-in result
  typedef struct {
    cmd_item_t  item;
    bit         typed;
    result_t    res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  at_response_receiver_unit DUT (.*);

  // receiver model state
  logic [63:0] m_prompt_bytes;
  logic [3:0]  m_prompt_len;
  logic [10:0] m_need_len;
  logic [7:0]  m_line [LINE_HOLD];
  int          m_line_cnt;
  bit          m_discarding;
  logic [7:0]  m_resp [RESP_DEPTH];
  int          m_resp_cnt;
  bit          m_task_on;
  logic [1:0]  m_mode;
  logic [63:0] m_hist;
  int          m_hist_fill;
  bit          m_dropped;

  result_t expected_results[$];
  int      errors;
  int      idle_cycles;
  bit      feeding;
  int      in_gap;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void push_result(logic [1:0] kind, logic [7:0] b, logic last);
    result_t r;
    r.kind = kind;
    r.data_byte = b;
    r.last_of_run = last;
    r.held_count = m_resp_cnt[10:0];
    r.overflow_seen = m_dropped;
    expected_results.push_back(r);
  endfunction

  function automatic void end_task(logic [1:0] kind);
    if (m_task_on) begin
      push_result(kind, 8'h00, 1'b0);
      m_task_on = 0;
      m_mode = MODE_LINE;
    end
    m_resp_cnt = 0;
    m_dropped = 0;
    m_hist = '0;
    m_hist_fill = 0;
  endfunction

  function automatic void close_line();
    int n;
    n = m_line_cnt;
    if (n <= 2) return;
    if (m_line[0] == CH_PLUS) begin
      for (int i = 0; i < n; i++) push_result(KIND_URC, m_line[i], i + 1 == n);
      return;
    end
    if (m_resp_cnt + n <= RESP_DEPTH) begin
      for (int i = 0; i < n; i++) m_resp[m_resp_cnt + i] = m_line[i];
      m_resp_cnt += n;
    end else begin
      m_dropped = 1;
    end
    if (m_line[0] == CH_O && m_line[1] == CH_K) end_task(KIND_OK);
    else if (n >= 5 && m_line[0] == CH_E && m_line[1] == CH_R && m_line[2] == CH_R
             && m_line[3] == CH_O && m_line[4] == CH_R) end_task(KIND_ERR);
  endfunction

  function automatic void line_in(logic [7:0] b);
    if (m_discarding) begin
      if (b == CH_NL) begin
        m_discarding = 0;
        m_line_cnt = 0;
      end
      return;
    end
    if (m_line_cnt >= LINE_HOLD) begin
      if (b == CH_NL) m_line_cnt = 0;
      else m_discarding = 1;
      return;
    end
    m_line[m_line_cnt] = b;
    m_line_cnt++;
    if (b == CH_NL) begin
      close_line();
      m_line_cnt = 0;
    end
  endfunction

  function automatic void prompt_in(logic [7:0] b);
    logic [63:0] mask;
    if (m_hist_fill < HIST_DEPTH) begin
      m_hist = {m_hist[55:0], b};
      m_hist_fill++;
    end
    if (m_prompt_len == 0 || m_prompt_len > PROMPT_MAX || m_prompt_len > m_hist_fill) return;
    mask = (m_prompt_len >= 8) ? '1 : ((64'd1 << (m_prompt_len * 8)) - 64'd1);
    if ((m_hist & mask) != (m_prompt_bytes & mask)) return;
    m_hist = '0;
    m_hist_fill = 0;
    if (m_need_len != 0) begin
      m_resp_cnt = 0;
      m_dropped = 0;
      m_mode = MODE_BINARY;
    end else begin
      end_task(KIND_OK);
    end
  endfunction

  function automatic void binary_in(logic [7:0] b);
    if (m_resp_cnt >= RESP_DEPTH) begin
      m_dropped = 1;
      return;
    end
    m_resp[m_resp_cnt] = b;
    m_resp_cnt++;
    if (m_resp_cnt >= m_need_len) end_task(KIND_OK);
  endfunction

  // advance the receiver model by one accepted item
  function automatic void predict_item(cmd_item_t it);
    case (it.cmd)
      CMD_BYTE: begin
        if (!m_task_on || m_mode == MODE_LINE) line_in(it.rx);
        else if (m_mode == MODE_PROMPT) prompt_in(it.rx);
        else binary_in(it.rx);
      end
      CMD_START: begin
        if (it.mode <= MODE_BINARY) begin
          m_task_on = 1;
          m_mode = it.mode;
        end
      end
      CMD_READ: begin
        push_result(KIND_READ, (it.idx < m_resp_cnt) ? m_resp[it.idx] : 8'h00, 1'b0);
      end
      default: ;
    endcase
  endfunction

  // wait the drawn gap, present the item, then draw the gap before the next one
  task automatic send_item(cmd_item_t it);
    repeat (in_gap) @(posedge clk);
    s_axis_tdata <= {4'd0, it.idx, it.mode, it.rx};
    s_axis_tuser <= it.cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    in_gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) in_gap = 0;
    if (in_gap != 0) s_axis_tvalid <= 1'b0;
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    if (in_gap == 0) begin
      s_axis_tvalid <= 1'b0;
      in_gap = 1;
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [63:0] value);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_PROMPT_BYTES: m_prompt_bytes = value;
      REG_PROMPT_LENGTH: m_prompt_len = value[3:0];
      default: m_need_len = value[10:0];
    endcase
  endtask

  task automatic set_regs(logic [63:0] pb, logic [3:0] pl, logic [10:0] nl);
    drain();
    write_reg(REG_PROMPT_BYTES, pb);
    write_reg(REG_PROMPT_LENGTH, {60'd0, pl});
    write_reg(REG_NEED_LENGTH, {53'd0, nl});
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_item_t mk(int c, int b, int md, int ix);
    cmd_item_t it;
    it.cmd = c[1:0];
    it.rx = b[7:0];
    it.mode = md[1:0];
    it.idx = ix[9:0];
    return it;
  endfunction

  // drive one item through the model, then the block
  task automatic apply(cmd_item_t it);
    predict_item(it);
    send_item(it);
  endtask

  task automatic send_line(string s, bit nl);
    for (int i = 0; i < s.len(); i++) apply(mk(CMD_BYTE, s[i], 0, $urandom));
    if (nl) apply(mk(CMD_BYTE, CH_NL, 0, $urandom));
  endtask

  function automatic string rand_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      byte c;
      c = byte'($urandom_range(8'h20, 8'hFF));
      s = {s, string'(c)};
    end
    return s;
  endfunction

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser[1:0] != want.kind)
          report($sformatf("kind %0d want %0d", m_axis_tuser[1:0], want.kind));
        if (m_axis_tdata[7:0] != want.data_byte)
          report($sformatf("data %h want %h", m_axis_tdata[7:0], want.data_byte));
        if (m_axis_tlast != want.last_of_run)
          report($sformatf("last %b want %b", m_axis_tlast, want.last_of_run));
        if (m_axis_tdata[18:8] != want.held_count)
          report($sformatf("length %0d want %0d", m_axis_tdata[18:8],
                           want.held_count));
        if (m_axis_tuser[2] != want.overflow_seen)
          report($sformatf("overflow %b want %b", m_axis_tuser[2], want.overflow_seen));
      end
    end
  end

  // random stall on the result side, with stretches of none
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    forever begin
      hold = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready) || !feeding && expected_results.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int phase;
    errors = 0;
    idle_cycles = 0;
    feeding = 1;
    in_gap = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_prompt_bytes = '0;
    m_prompt_len = '0;
    m_need_len = '0;
    m_line_cnt = 0;
    m_discarding = 0;
    m_resp_cnt = 0;
    m_task_on = 0;
    m_mode = MODE_LINE;
    m_hist = '0;
    m_hist_fill = 0;
    m_dropped = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: reads after reset, task ends, urc, commands ignored
    r.typed = 1; r.item = mk(CMD_READ, 8'hFF, 2'd3, 10'd0);
    r.res = '{KIND_READ, 8'h00, 1'b0, 11'd0, 1'b0}; rows.push_back(r);
    r.item = mk(CMD_READ, 8'h00, 2'd0, 10'd1023); rows.push_back(r);
    r.typed = 0;
    r.item = mk(2'd3, 8'hAA, 2'd1, 10'h3FF); rows.push_back(r);
    r.item = mk(CMD_START, 8'h55, 2'd3, 10'h155); rows.push_back(r);
    r.item = mk(CMD_START, 8'h00, MODE_LINE, 10'h2AA); rows.push_back(r);
    foreach (rows[i]) begin
      predict_item(rows[i].item);
      if (rows[i].typed) begin
        void'(expected_results.pop_back());
        expected_results.push_back(rows[i].res);
      end
      send_item(rows[i].item);
    end
    send_line("+CSQ: 9", 1);
    send_line("ab", 1);
    send_line("OK", 1);
    apply(mk(CMD_START, 0, MODE_LINE, 0));
    send_line("DATA", 1);
    apply(mk(CMD_READ, 0, 0, 10'd2));
    send_line("ERROR", 1);

    // prompt then binary, then a prompt of the maximum length ending at once
    set_regs(64'h0000_0000_0000_3E20, 4'd2, 11'd3);
    apply(mk(CMD_START, 0, MODE_PROMPT, 0));
    send_line("x> ", 0);
    apply(mk(CMD_BYTE, 8'h00, 0, 0));
    apply(mk(CMD_BYTE, 8'hFF, 0, 0));
    apply(mk(CMD_BYTE, 8'h7E, 0, 0));
    set_regs(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 11'd0);
    apply(mk(CMD_START, 0, MODE_PROMPT, 0));
    for (int i = 0; i < 8; i++) apply(mk(CMD_BYTE, 8'hFF, 0, 0));
    // over-long line and a full buffer discard
    send_line(rand_text(70), 1);
    send_line("OK", 1);
    // prompt length above the limit never matches
    set_regs(64'h0, 4'd15, 11'd1024);
    apply(mk(CMD_START, 0, MODE_PROMPT, 0));
    for (int i = 0; i < 20; i++) apply(mk(CMD_BYTE, 8'h00, 0, 0));
    apply(mk(CMD_START, 0, MODE_LINE, 0));
    send_line("OK", 1);

    // random phases
    for (phase = 0; phase < 3; phase++) begin
      logic [3:0] pl;
      pl = 4'($urandom_range(1, 3));
      set_regs({$urandom, $urandom}, pl,
               (phase == 2) ? 11'd1024 : 11'($urandom_range(0, 12)));
      for (int n = 0; n < 7; n++) begin
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6) send_line({"+", rand_text($urandom_range(0, 6))}, 1);
        else if (pick < 10) send_line(rand_text($urandom_range(0, 8)),
                                      $urandom_range(0, 1) == 1);
        else if (pick < 11) send_line("OK", 1);
        else if (pick < 12) send_line("ERROR", 1);
        else if (pick < 14) begin
          apply(mk(CMD_START, 0, $urandom_range(0, 3), $urandom));
          if (m_mode == MODE_PROMPT && m_task_on)
            for (int i = pl - 1; i >= 0; i--)
              apply(mk(CMD_BYTE, m_prompt_bytes[i*8 +: 8], 0, 0));
        end
        else if (pick < 17) apply(mk(CMD_READ, $urandom, $urandom,
                                     $urandom_range(0, m_resp_cnt + 2)));
        else if (pick < 19) apply(mk(CMD_BYTE, $urandom, $urandom, $urandom));
        else apply(mk($urandom_range(0, 3), $urandom, $urandom, $urandom));
      end
      // return to a known idle mode
      apply(mk(CMD_START, 0, MODE_LINE, 0));
      send_line("OK", 1);
    end

    feeding = 0;
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
